// ----- rtl/assert_macros.svh -----
// assertion macros shared by the queue rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define AST_HOLD(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

// condition must never be seen outside reset
`define AST_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");

`endif

// ----- rtl/plq_pkg.sv -----
// types, constants and helpers of the priority landing queue
package plq_pkg;

	localparam int unsigned QUEUE_DEPTH_DEF = 16;

	localparam int unsigned PRIO_W      = 2;
	localparam int unsigned STAMP_W     = 16;
	localparam int unsigned TICK_W      = 16;
	localparam int unsigned INTERVAL_W  = 8;
	localparam int unsigned COUNT_W     = 16;
	localparam int unsigned SUM_W       = 32;
	localparam int unsigned AVG_W       = 16;
	localparam int unsigned LEVEL_W     = 5;
	localparam int unsigned DIV_W       = 16;
	localparam int unsigned DIV_CNT_W   = $clog2(DIV_W);
	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W  = 16;

	localparam logic [PRIO_W-1:0] PRIO_MAX = PRIO_W'(2);

	localparam logic [CFG_INDEX_W-1:0] CFG_LANDING_INTERVAL = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] CFG_RUN_LENGTH       = CFG_INDEX_W'(1);

	localparam logic [INTERVAL_W-1:0] INTERVAL_RST   = INTERVAL_W'(1);
	localparam logic [TICK_W-1:0]     RUN_LENGTH_RST = '1;

	typedef struct packed {
		logic [PRIO_W-1:0]  prio;
		logic [STAMP_W-1:0] stamp;
	} slot_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_POP
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		slot_t    slot;
	} cell_cmd_t;

	typedef struct packed {
		logic              arrival;
		logic [PRIO_W-1:0] priority_req;
	} in_word_t;

	typedef struct packed {
		logic               landed;
		logic [PRIO_W-1:0]  landed_priority;
		logic [TICK_W-1:0]  wait_time;
		logic               empty_slot;
		logic               dropped;
		logic               run_over;
		logic [COUNT_W-1:0] landed_count;
		logic [AVG_W-1:0]   average_wait;
		logic [LEVEL_W-1:0] queue_level;
	} out_word_t;

	typedef struct packed {
		logic [CFG_INDEX_W-1:0] index;
		logic [CFG_DATA_W-1:0]  data;
	} cfg_word_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] hi;
		logic [DIV_W-1:0] lo;
		logic [DIV_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quotient;
		logic [DIV_W-1:0] remainder;
	} div_rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INSERT,
		ST_MOD,
		ST_POP,
		ST_AVG,
		ST_DIV,
		ST_OUT
	} state_t;

	// priority three behaves as the top priority
	function automatic logic [PRIO_W-1:0] clamp_prio(input logic [PRIO_W-1:0] p);
		return (p > PRIO_MAX) ? PRIO_MAX : p;
	endfunction

endpackage

// ----- rtl/plq_chan_if.sv -----
// valid/ready channel carrying one word of a chosen type
interface plq_chan_if #(
	parameter type word_t = logic
) ();
	logic  valid;
	logic  ready;
	word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/plq_cell.sv -----
// one queue cell: holds a slot, shifts right on insert and left on pop
module plq_cell (
	input  logic              clk,
	input  plq_pkg::cell_cmd_t cmd,
	input  logic              occupied,
	input  logic              left_ge,
	input  plq_pkg::slot_t    left_slot,
	input  plq_pkg::slot_t    right_slot,
	output logic              ge,
	output plq_pkg::slot_t    slot
);
	import plq_pkg::*;

	slot_t slot_q;

	// entry stays ahead of an arrival of equal or lower priority
	assign ge   = occupied && (slot_q.prio >= cmd.slot.prio);
	assign slot = slot_q;

	always_ff @(posedge clk) begin
		case (cmd.op)
			CELL_INSERT: begin
				if (!ge) begin
					slot_q <= left_ge ? cmd.slot : left_slot;
				end
			end
			CELL_POP: begin
				slot_q <= right_slot;
			end
			default: begin
				slot_q <= slot_q;
			end
		endcase
	end

endmodule

// ----- rtl/plq_div.sv -----
// restoring divider, one quotient bit per cycle, high half below divisor
`include "assert_macros.svh"

module plq_div (
	input  logic              clk,
	input  logic              arst_n,
	input  plq_pkg::div_req_t req,
	output plq_pkg::div_rsp_t rsp
);
	import plq_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0]     rem_q;
	logic [DIV_W-1:0]     quo_q;
	logic [DIV_W-1:0]     dvs_q;

	logic [DIV_W:0] trial;
	logic [DIV_W:0] diff;
	logic           fits;

	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.hi;
			quo_q <= req.lo;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

	`AST_NEVER(a_div_no_restart, clk, arst_n, req.start && busy_q)
	`AST_HOLD(a_div_done_after_busy, clk, arst_n, done_q |-> $past(busy_q))
	`AST_HOLD(a_div_start_runs, clk, arst_n, req.start |=> busy_q)

endmodule

// ----- rtl/priority_landing_queue.sv -----
// steps: accept, insert, landing check on the divider (skipped when interval is 0), pop, output
// a landing adds an average step and the serial divider for the average (unless it saturates)
// ticks past the run length go from accept straight to output; one tick is in flight at a
// time, as arrivals are taken only in the idle state
// reset clears fill, tick, counts, average and output valid, interval to 1 and
// run length to 65535; slot contents are left as they are
`include "assert_macros.svh"

module priority_landing_queue #(
	parameter int unsigned QUEUE_DEPTH = plq_pkg::QUEUE_DEPTH_DEF
) (
	input logic        clk,
	input logic        arst_n,
	plq_chan_if.sink   arrivals,
	plq_chan_if.source results,
	plq_chan_if.sink   cfg
);
	import plq_pkg::*;

	localparam int unsigned FILL_W = $clog2(QUEUE_DEPTH + 1);

	state_t state_q, state_d;

	logic [FILL_W-1:0]     fill_q;
	logic [TICK_W-1:0]     tick_q;
	logic [COUNT_W-1:0]    departures_q;
	logic [SUM_W-1:0]      wait_sum_q;
	logic [AVG_W-1:0]      avg_q;
	logic [INTERVAL_W-1:0] interval_q;
	logic [TICK_W-1:0]     run_length_q;

	logic              do_insert_q;
	logic [PRIO_W-1:0] prio_q;
	logic              landed_q;
	logic [PRIO_W-1:0] lprio_q;
	logic [TICK_W-1:0] wait_q;
	logic              empty_q;
	logic              dropped_q;
	logic              over_q;

	logic      out_valid_q;
	out_word_t out_q;
	logic      out_load;

	cell_cmd_t        cmd;
	slot_t            slots      [QUEUE_DEPTH];
	slot_t            left_slots [QUEUE_DEPTH];
	slot_t            right_slots[QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] ge;
	logic [QUEUE_DEPTH-1:0] left_ge;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic              accept;
	logic              over_now;
	logic              full;
	logic              land_now;
	logic              avg_sat;
	logic [TICK_W-1:0] wait_now;
	logic [SUM_W:0]    sum_next;

	assign accept   = arrivals.valid && arrivals.ready;
	assign over_now = tick_q >= run_length_q;
	assign full     = fill_q == FILL_W'(QUEUE_DEPTH);
	assign land_now = (interval_q == '0) || (div_rsp.remainder == '0);
	assign avg_sat  = wait_sum_q[SUM_W-1:AVG_W] >= departures_q;
	assign wait_now = tick_q - slots[0].stamp;
	assign sum_next = {1'b0, wait_sum_q} + (SUM_W + 1)'(wait_now);

	// cell row: new word enters at the left, pops pull from the right
	assign left_ge = {ge[QUEUE_DEPTH-2:0], 1'b1};

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_first
			assign left_slots[i] = cmd.slot;
		end else begin : g_inner_left
			assign left_slots[i] = slots[i-1];
		end
		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign right_slots[i] = slots[i];
		end else begin : g_inner_right
			assign right_slots[i] = slots[i+1];
		end

		plq_cell u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.occupied   (FILL_W'(i) < fill_q),
			.left_ge    (left_ge[i]),
			.left_slot  (left_slots[i]),
			.right_slot (right_slots[i]),
			.ge         (ge[i]),
			.slot       (slots[i])
		);
	end

	plq_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		arrivals.ready = 1'b0;
		out_load       = 1'b0;
		cmd.op         = CELL_HOLD;
		cmd.slot.prio  = prio_q;
		cmd.slot.stamp = tick_q;
		div_req        = '0;
		case (state_q)
			ST_IDLE: begin
				arrivals.ready = 1'b1;
				if (arrivals.valid) begin
					state_d = over_now ? ST_OUT : ST_INSERT;
				end
			end
			ST_INSERT: begin
				if (do_insert_q) begin
					cmd.op = CELL_INSERT;
				end
				if (interval_q == '0) begin
					state_d = ST_POP;
				end else begin
					// tick modulo interval on the shared divider
					div_req.start   = 1'b1;
					div_req.hi      = '0;
					div_req.lo      = tick_q;
					div_req.divisor = DIV_W'(interval_q);
					state_d         = ST_MOD;
				end
			end
			ST_MOD: begin
				if (div_rsp.done) begin
					state_d = ST_POP;
				end
			end
			ST_POP: begin
				if (land_now && (fill_q != '0)) begin
					cmd.op  = CELL_POP;
					state_d = ST_AVG;
				end else begin
					state_d = ST_OUT;
				end
			end
			ST_AVG: begin
				if (avg_sat) begin
					state_d = ST_OUT;
				end else begin
					div_req.start   = 1'b1;
					div_req.hi      = wait_sum_q[SUM_W-1:AVG_W];
					div_req.lo      = wait_sum_q[AVG_W-1:0];
					div_req.divisor = departures_q;
					state_d         = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_rsp.done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!out_valid_q || results.ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q       <= '0;
			tick_q       <= '0;
			departures_q <= '0;
			wait_sum_q   <= '0;
			avg_q        <= '0;
			interval_q   <= INTERVAL_RST;
			run_length_q <= RUN_LENGTH_RST;
			out_valid_q  <= 1'b0;
			do_insert_q  <= 1'b0;
			landed_q     <= 1'b0;
			empty_q      <= 1'b0;
			dropped_q    <= 1'b0;
			over_q       <= 1'b0;
		end else begin
			if (accept) begin
				over_q      <= over_now;
				dropped_q   <= !over_now && arrivals.data.arrival && full;
				do_insert_q <= !over_now && arrivals.data.arrival && !full;
				landed_q    <= 1'b0;
				empty_q     <= 1'b0;
			end

			if (cmd.op == CELL_INSERT) begin
				fill_q <= fill_q + FILL_W'(1);
			end

			if (state_q == ST_POP) begin
				tick_q <= tick_q + TICK_W'(1);
				if (land_now) begin
					if (fill_q == '0) begin
						empty_q <= 1'b1;
					end else begin
						landed_q <= 1'b1;
						fill_q   <= fill_q - FILL_W'(1);
						if (departures_q != '1) begin
							departures_q <= departures_q + COUNT_W'(1);
						end
						wait_sum_q <= sum_next[SUM_W] ? '1 : sum_next[SUM_W-1:0];
					end
				end
			end

			if ((state_q == ST_AVG) && avg_sat) begin
				avg_q <= '1;
			end
			if ((state_q == ST_DIV) && div_rsp.done) begin
				avg_q <= div_rsp.quotient;
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end

			if (cfg.valid && cfg.ready) begin
				case (cfg.data.index)
					CFG_LANDING_INTERVAL: interval_q <= cfg.data.data[INTERVAL_W-1:0];
					CFG_RUN_LENGTH:       run_length_q <= cfg.data.data[TICK_W-1:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			prio_q  <= clamp_prio(arrivals.data.priority_req);
			lprio_q <= '0;
			wait_q  <= '0;
		end
		if ((state_q == ST_POP) && land_now && (fill_q != '0)) begin
			lprio_q <= slots[0].prio;
			wait_q  <= wait_now;
		end
		if (out_load) begin
			out_q.landed          <= landed_q;
			out_q.landed_priority <= lprio_q;
			out_q.wait_time       <= wait_q;
			out_q.empty_slot      <= empty_q;
			out_q.dropped         <= dropped_q;
			out_q.run_over        <= over_q;
			out_q.landed_count    <= departures_q;
			out_q.average_wait    <= avg_q;
			out_q.queue_level     <= LEVEL_W'(fill_q);
		end
	end

	assign cfg.ready     = 1'b1;
	assign results.valid = out_valid_q;
	assign results.data  = out_q;

	`AST_NEVER(a_fill_bound, clk, arst_n, fill_q > FILL_W'(QUEUE_DEPTH))
	`AST_NEVER(a_landed_exclusive, clk, arst_n, landed_q && (empty_q || over_q || dropped_q && full))
	`AST_HOLD(a_div_done_in_wait, clk, arst_n, div_rsp.done |-> (state_q == ST_MOD || state_q == ST_DIV))

endmodule
